FILE: src/aes_ctr_pkg.sv
// Shared types, constants and AES helper functions for the CTR encryptor.
`default_nettype none
package aes_ctr_pkg;
   localparam int unsigned RK_WORDS  = 60;
   localparam int unsigned KEY_WORDS = 8;

   typedef enum logic [2:0] {
      CSR_KEY0 = 3'd0,
      CSR_KEY1 = 3'd1,
      CSR_KEY2 = 3'd2,
      CSR_KEY3 = 3'd3,
      CSR_CTR_HI = 3'd4,
      CSR_CTR_LO = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_KLOAD  = 5'b00010,
      ST_KEXP   = 5'b00100,
      ST_ROUND  = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction
endpackage
`default_nettype wire

FILE: src/aes_ctr_if.sv
// Valid/ready channel interfaces for request, response and register writes.
`default_nettype none
interface aes_ctr_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_hi;
   logic [63:0] data_lo;
   logic [4:0]  valid_bytes;
   logic        restart;
   modport source (output valid, data_hi, data_lo, valid_bytes, restart, input ready);
   modport sink (input valid, data_hi, data_lo, valid_bytes, restart, output ready);
endinterface

interface aes_ctr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_hi;
   logic [63:0] result_lo;
   logic [4:0]  valid_bytes_out;
   modport source (output valid, result_hi, result_lo, valid_bytes_out, input ready);
   modport sink (input valid, result_hi, result_lo, valid_bytes_out, output ready);
endinterface

interface aes_ctr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/aes_ctr_round.sv
// One AES round over the 128-bit state: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
`default_nettype none
module aes_ctr_round
   import aes_ctr_pkg::*;
(
   input  wire logic [127:0] state_in,
   input  wire logic [127:0] round_key,
   input  wire logic         last_round,
   output logic      [127:0] state_out
);
   logic [7:0] s  [16];
   logic [7:0] t  [16];
   logic [7:0] m  [16];
   logic [7:0] d  [16];

   always_comb begin
      for (int k = 0; k < 16; k++) begin
         s[k] = state_in[127-8*k -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
         end
      end
      for (int k = 0; k < 16; k++) begin
         d[k] = xtime(t[k]);
      end
      for (int c = 0; c < 4; c++) begin
         m[4*c]   = d[4*c] ^ d[4*c+1] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
         m[4*c+1] = t[4*c] ^ d[4*c+1] ^ d[4*c+2] ^ t[4*c+2] ^ t[4*c+3];
         m[4*c+2] = t[4*c] ^ t[4*c+1] ^ d[4*c+2] ^ d[4*c+3] ^ t[4*c+3];
         m[4*c+3] = d[4*c] ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ d[4*c+3];
      end
      for (int k = 0; k < 16; k++) begin
         state_out[127-8*k -: 8] = (last_round ? t[k] : m[k]) ^ round_key[127-8*k -: 8];
      end
   end
endmodule
`default_nettype wire

FILE: src/aes256_ctr_encrypt.sv
// Top level: AES-256 CTR encryptor with round-key memory and iterative round unit.
// One block goes from accept to result valid via a round-key fetch, the
// initial key addition, fourteen rounds through one shared round unit (each
// waiting on one 128-bit read of the round-key memory), and the output register.
// A restart, or the first block after reset, first runs key expansion: it loads
// the 8 key words, then computes the other 52 at one round-key word per cycle.
// The block takes no new request until the previous result beat has left.
`default_nettype none
module aes256_ctr_encrypt
   import aes_ctr_pkg::*;
#(
   parameter int unsigned NUM_ROUNDS = 14
) (
   input  wire logic clock,
   input  wire logic reset,
   aes_ctr_req_if.sink   req,
   aes_ctr_rsp_if.source rsp,
   aes_ctr_csr_if.sink   csr
);
   localparam int unsigned NW = 4 * (NUM_ROUNDS + 1);
   localparam int unsigned WAW = $clog2(NW);
   localparam int unsigned RAW = $clog2(NUM_ROUNDS + 1);

   logic [63:0] key_ff [4];
   logic [63:0] ctr_init_hi_ff, ctr_init_lo_ff;
   logic [127:0] ctr_ff;
   logic keys_ready_ff;

   // round keys kept as 4 word banks so all words of a round key read out together
   logic [31:0] rk_mem0 [NUM_ROUNDS+1];
   logic [31:0] rk_mem1 [NUM_ROUNDS+1];
   logic [31:0] rk_mem2 [NUM_ROUNDS+1];
   logic [31:0] rk_mem3 [NUM_ROUNDS+1];
   logic [127:0] rk_rd_ff;
   logic [RAW-1:0] rk_raddr;

   // sliding window of the last 8 expanded words
   logic [31:0] win_ff [8];
   logic [WAW-1:0] widx_ff;
   logic [7:0] rcon_ff;

   state_type state_ff;
   logic [RAW-1:0] round_ff;
   logic fetch_ff;
   logic [127:0] st_ff;
   logic [127:0] data_ff;
   logic [4:0] vb_ff;
   logic [127:0] res_ff;
   logic [4:0] vbo_ff;
   logic out_valid_ff;

   logic [127:0] round_out;
   logic [31:0] new_word;
   logic we;
   logic [WAW-1:0] waddr;
   logic [31:0] wdata;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '{default: '0};
         ctr_init_hi_ff <= '0;
         ctr_init_lo_ff <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_KEY0:   key_ff[0] <= csr.data;
            CSR_KEY1:   key_ff[1] <= csr.data;
            CSR_KEY2:   key_ff[2] <= csr.data;
            CSR_KEY3:   key_ff[3] <= csr.data;
            CSR_CTR_HI: ctr_init_hi_ff <= csr.data;
            CSR_CTR_LO: ctr_init_lo_ff <= csr.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [31:0] t;
      t = win_ff[7];
      if (widx_ff[2:0] == 3'd0) begin
         t = sub_word({t[23:0], t[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (widx_ff[2:0] == 3'd4) begin
         t = sub_word(t);
      end
      new_word = win_ff[0] ^ t;
   end

   always_comb begin
      we = 1'b0;
      waddr = widx_ff;
      wdata = new_word;
      if (state_ff == ST_KLOAD) begin
         we = 1'b1;
         wdata = widx_ff[0] ? key_ff[widx_ff[2:1]][31:0] : key_ff[widx_ff[2:1]][63:32];
      end else if (state_ff == ST_KEXP) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         case (waddr[1:0])
            2'd0: rk_mem0[waddr[WAW-1:2]] <= wdata;
            2'd1: rk_mem1[waddr[WAW-1:2]] <= wdata;
            2'd2: rk_mem2[waddr[WAW-1:2]] <= wdata;
            default: rk_mem3[waddr[WAW-1:2]] <= wdata;
         endcase
      end
      rk_rd_ff <= {rk_mem0[rk_raddr], rk_mem1[rk_raddr], rk_mem2[rk_raddr], rk_mem3[rk_raddr]};
   end

   // the key read runs one round ahead; hold the last row on the final round
   assign rk_raddr = (round_ff > RAW'(NUM_ROUNDS)) ? RAW'(NUM_ROUNDS) : round_ff;

   aes_ctr_round u_round (
      .state_in   (st_ff),
      .round_key  (rk_rd_ff),
      .last_round (round_ff == RAW'(NUM_ROUNDS + 1)),
      .state_out  (round_out)
   );

   assign req.ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.result_hi = res_ff[127:64];
   assign rsp.result_lo = res_ff[63:0];
   assign rsp.valid_bytes_out = vbo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         keys_ready_ff <= 1'b0;
         ctr_ff <= '0;
         out_valid_ff <= 1'b0;
         round_ff <= '0;
         fetch_ff <= 1'b0;
         widx_ff <= '0;
         rcon_ff <= 8'h01;
      end else begin
         if (rsp.valid && rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  data_ff <= {req.data_hi, req.data_lo};
                  vb_ff <= req.valid_bytes;
                  round_ff <= '0;
                  fetch_ff <= 1'b1;
                  if (req.restart || !keys_ready_ff) begin
                     ctr_ff <= {ctr_init_hi_ff, ctr_init_lo_ff};
                     widx_ff <= '0;
                     rcon_ff <= 8'h01;
                     state_ff <= ST_KLOAD;
                  end else begin
                     state_ff <= ST_ROUND;
                  end
               end
            end
            ST_KLOAD: begin
               for (int k = 0; k < 7; k++) begin
                  win_ff[k] <= win_ff[k+1];
               end
               win_ff[7] <= wdata;
               widx_ff <= widx_ff + 1'b1;
               if (widx_ff == WAW'(KEY_WORDS - 1)) begin
                  state_ff <= ST_KEXP;
               end
            end
            ST_KEXP: begin
               for (int k = 0; k < 7; k++) begin
                  win_ff[k] <= win_ff[k+1];
               end
               win_ff[7] <= new_word;
               widx_ff <= widx_ff + 1'b1;
               if (widx_ff[2:0] == 3'd0) begin
                  rcon_ff <= xtime(rcon_ff);
               end
               if (widx_ff == WAW'(NW - 1)) begin
                  keys_ready_ff <= 1'b1;
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               // first cycle only fetches round key 0
               if (fetch_ff) begin
                  fetch_ff <= 1'b0;
                  round_ff <= round_ff + 1'b1;
               end else if (round_ff == RAW'(1)) begin
                  st_ff <= ctr_ff ^ rk_rd_ff;
                  round_ff <= round_ff + 1'b1;
               end else begin
                  st_ff <= round_out;
                  if (round_ff == RAW'(NUM_ROUNDS + 1)) begin
                     state_ff <= ST_OUT;
                  end else begin
                     round_ff <= round_ff + 1'b1;
                  end
               end
            end
            ST_OUT: begin
               for (int k = 0; k < 16; k++) begin
                  res_ff[127-8*k -: 8] <= (5'(k) < vb_ff) ?
                     (st_ff[127-8*k -: 8] ^ data_ff[127-8*k -: 8]) : 8'h00;
               end
               vbo_ff <= vb_ff;
               out_valid_ff <= 1'b1;
               ctr_ff <= ctr_ff + 128'd1;
               round_ff <= '0;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // rounds only run with an expanded key
   a_keys: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (keys_ready_ff || widx_ff == WAW'(NW)) || keys_ready_ff)
      else $error("round without key");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready)
      else $error("ready while busy");
   a_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |=> out_valid_ff)
      else $error("result lost");
endmodule
`default_nettype wire
